/* hdl/assert_macros.svh */
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define SLCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define SLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/slcd_pkg.sv */
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants of the serial TFT panel init and fill controller.
// ----------------------------------------------------------------------------
package slcd_pkg;

    localparam int COORD_BITS_DEF = 10;

    localparam logic [15:0] TPM_RESET      = 16'd1000;
    localparam logic [15:0] LAST_COL_RESET = 16'd79;
    localparam logic [15:0] LAST_ROW_RESET = 16'd159;

    // panel commands
    localparam logic [7:0] CMD_SLEEP_OUT = 8'h11;
    localparam logic [7:0] CMD_DISP_ON   = 8'h29;
    localparam logic [7:0] CMD_COLUMN    = 8'h2A;
    localparam logic [7:0] CMD_ROW       = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

    // wait lengths in milliseconds
    localparam logic [7:0] MS_SHORT = 8'd10;
    localparam logic [7:0] MS_LONG  = 8'd120;

    // register indexes on the config port
    localparam logic [1:0] REG_TPM      = 2'd0;
    localparam logic [1:0] REG_LAST_COL = 2'd1;
    localparam logic [1:0] REG_LAST_ROW = 2'd2;

    typedef enum logic [11:0] {
        ST_RST_HIGH1 = 12'b0000_0000_0001,
        ST_RST_LOW   = 12'b0000_0000_0010,
        ST_RST_HIGH2 = 12'b0000_0000_0100,
        ST_SLEEP_OUT = 12'b0000_0000_1000,
        ST_WAIT_WAKE = 12'b0000_0001_0000,
        ST_DISP_ON   = 12'b0000_0010_0000,
        ST_WAIT_DISP = 12'b0000_0100_0000,
        ST_COLUMN    = 12'b0000_1000_0000,
        ST_ROW       = 12'b0001_0000_0000,
        ST_MEM_WRITE = 12'b0010_0000_0000,
        ST_PIXELS    = 12'b0100_0000_0000,
        ST_IDLE      = 12'b1000_0000_0000
    } t_step;

    // one tick request
    typedef struct packed {
        logic        start_fill;
        logic [15:0] fill_color;
    } t_tick;

    // pin levels and flags of one tick
    typedef struct packed {
        logic serial_clock;
        logic serial_data;
        logic chip_select_n;
        logic data_select;
        logic panel_reset_n;
        logic busy;
        logic ready;
    } t_pins;

endpackage

/* hdl/slcd_front.sv */
// ----------------------------------------------------------------------------
// slcd_front
// Input side: takes tick requests and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module slcd_front
    import slcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_start_fill,
    input  logic [15:0] i_fill_color,
    output logic        o_q_valid,
    output t_tick       o_q_tick,
    input  logic        i_q_pop
);

    t_tick      r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;
    logic       push;

    assign o_in_stall = (r_count == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_tick   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = push ? ~r_wptr : r_wptr;
        n_rptr  = i_q_pop ? ~r_rptr : r_rptr;
        n_count = r_count + 2'(push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= '{start_fill: i_start_fill, fill_color: i_fill_color};
        end
    end

endmodule

/* hdl/slcd_seq.sv */
// ----------------------------------------------------------------------------
// slcd_seq
// Back side: pin-level sequencer for power-up and fills, with output register.
// ----------------------------------------------------------------------------
module slcd_seq
    import slcd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [15:0]           i_ticks_per_ms,
    input  logic [COORD_BITS-1:0] i_last_column,
    input  logic [COORD_BITS-1:0] i_last_row,
    input  logic                  i_q_valid,
    input  t_tick                 i_q_tick,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_pins                 o_pins
);

    localparam int CW1    = COORD_BITS + 1;
    localparam int PROD_W = 2 * CW1;
    localparam int PIX_W  = 2 * COORD_BITS;

    t_step             r_step, n_step;
    logic [6:0]        r_ms, n_ms;
    logic [15:0]       r_tick, n_tick;
    logic [7:0]        r_shift, n_shift;
    logic [2:0]        r_bit, n_bit;
    logic              r_phase, n_phase;
    logic [2:0]        r_widx, n_widx;
    logic [PIX_W-1:0]  r_pix, n_pix;
    logic              r_half, n_half;
    logic [15:0]       r_color, n_color;
    logic              r_init, n_init;
    logic [PIX_W-1:0]  r_last_pix;
    logic              r_out_valid;
    t_pins             r_out;

    logic              go;
    logic              shifting;
    t_pins             pins;
    logic [CW1-1:0]    col_n, row_n;
    logic [PROD_W-1:0] prod;
    logic [15:0]       coord16;
    logic [2:0]        widx_inc;
    logic [7:0]        win_byte;
    logic [7:0]        ms_limit;
    logic              tick_wrap, ms_wrap;

    assign go      = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop = go;

    assign o_out_valid = r_out_valid;
    assign o_pins      = r_out;

    // last pixel index follows the window; registered so the multiply stands alone
    assign col_n = CW1'(i_last_column) + CW1'(1);
    assign row_n = CW1'(i_last_row) + CW1'(1);
    assign prod  = PROD_W'(col_n) * PROD_W'(row_n);

    always_ff @(posedge i_clk) begin
        r_last_pix <= PIX_W'(prod - PROD_W'(1));
    end

    assign shifting = (r_step == ST_SLEEP_OUT) || (r_step == ST_DISP_ON) ||
                      (r_step == ST_COLUMN) || (r_step == ST_ROW) ||
                      (r_step == ST_MEM_WRITE) || (r_step == ST_PIXELS);

    // window byte following the current one: cmd 00 00 hi lo
    assign coord16  = (r_step == ST_COLUMN) ? 16'(i_last_column) : 16'(i_last_row);
    assign widx_inc = r_widx + 3'd1;
    always_comb begin
        if (widx_inc == 3'd3) begin
            win_byte = coord16[15:8];
        end else if (widx_inc == 3'd4) begin
            win_byte = coord16[7:0];
        end else begin
            win_byte = 8'd0;
        end
    end

    assign ms_limit  = ((r_step == ST_RST_HIGH2) || (r_step == ST_WAIT_WAKE)) ? MS_LONG
                                                                                 : MS_SHORT;
    assign tick_wrap = ({1'b0, r_tick} + 17'd1) >= {1'b0, i_ticks_per_ms};
    assign ms_wrap   = ({1'b0, r_ms} + 8'd1) >= ms_limit;

    always_comb begin
        pins.serial_clock  = 1'b1;
        pins.serial_data   = 1'b0;
        pins.chip_select_n = 1'b1;
        pins.data_select   = 1'b0;
        if (shifting) begin
            pins.serial_clock  = r_phase;
            pins.serial_data   = r_shift[r_bit];
            pins.chip_select_n = 1'b0;
            pins.data_select   = (r_step == ST_PIXELS) ||
                                 (((r_step == ST_COLUMN) || (r_step == ST_ROW)) &&
                                  (r_widx != 3'd0));
        end
        pins.panel_reset_n = (r_step != ST_RST_LOW);
        pins.busy          = (r_step != ST_IDLE);
        pins.ready         = r_init;
    end

    always_comb begin
        n_step  = r_step;
        n_ms    = r_ms;
        n_tick  = r_tick;
        n_shift = r_shift;
        n_bit   = r_bit;
        n_phase = r_phase;
        n_widx  = r_widx;
        n_pix   = r_pix;
        n_half  = r_half;
        n_color = r_color;
        n_init  = r_init;
        if (shifting) begin
            if (!r_phase) begin
                n_phase = 1'b1;
            end else begin
                n_phase = 1'b0;
                if (r_bit != 3'd0) begin
                    n_bit = r_bit - 3'd1;
                end else begin
                    n_bit = 3'd7;
                    // last bit of the byte is out
                    unique case (r_step)
                        ST_SLEEP_OUT: n_step = ST_WAIT_WAKE;
                        ST_DISP_ON:   n_step = ST_WAIT_DISP;
                        ST_COLUMN, ST_ROW: begin
                            if (r_widx < 3'd4) begin
                                n_widx  = widx_inc;
                                n_shift = win_byte;
                            end else begin
                                n_widx = 3'd0;
                                if (r_step == ST_COLUMN) begin
                                    n_step  = ST_ROW;
                                    n_shift = CMD_ROW;
                                end else begin
                                    n_step  = ST_MEM_WRITE;
                                    n_shift = CMD_MEM_WRITE;
                                end
                            end
                        end
                        ST_MEM_WRITE: begin
                            if (r_init) begin
                                n_step  = ST_PIXELS;
                                n_pix   = '0;
                                n_half  = 1'b0;
                                n_shift = r_color[15:8];
                            end else begin
                                n_init = 1'b1;
                                n_step = ST_IDLE;
                            end
                        end
                        default: begin
                            if (!r_half) begin
                                n_half  = 1'b1;
                                n_shift = r_color[7:0];
                            end else begin
                                n_half = 1'b0;
                                if (r_pix >= r_last_pix) begin
                                    n_step = ST_IDLE;
                                end else begin
                                    n_pix   = r_pix + PIX_W'(1);
                                    n_shift = r_color[15:8];
                                end
                            end
                        end
                    endcase
                end
            end
        end else if (r_step == ST_IDLE) begin
            if (i_q_tick.start_fill) begin
                n_color = i_q_tick.fill_color;
                n_step  = ST_COLUMN;
                n_widx  = 3'd0;
                n_shift = CMD_COLUMN;
                n_bit   = 3'd7;
                n_phase = 1'b0;
            end
        end else begin
            // millisecond waits
            if (tick_wrap) begin
                n_tick = 16'd0;
                n_ms   = ms_wrap ? 7'd0 : r_ms + 7'd1;
            end else begin
                n_tick = r_tick + 16'd1;
            end
            if (tick_wrap && ms_wrap) begin
                n_bit   = 3'd7;
                n_phase = 1'b0;
                unique case (r_step)
                    ST_RST_HIGH1: n_step = ST_RST_LOW;
                    ST_RST_LOW:   n_step = ST_RST_HIGH2;
                    ST_RST_HIGH2: begin
                        n_step  = ST_SLEEP_OUT;
                        n_shift = CMD_SLEEP_OUT;
                    end
                    ST_WAIT_WAKE: begin
                        n_step  = ST_DISP_ON;
                        n_shift = CMD_DISP_ON;
                    end
                    default: begin
                        n_step  = ST_COLUMN;
                        n_widx  = 3'd0;
                        n_shift = CMD_COLUMN;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_RST_HIGH1;
            r_ms        <= 7'd0;
            r_tick      <= 16'd0;
            r_shift     <= 8'd0;
            r_bit       <= 3'd7;
            r_phase     <= 1'b0;
            r_widx      <= 3'd0;
            r_pix       <= '0;
            r_half      <= 1'b0;
            r_color     <= 16'd0;
            r_init      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (go) begin
                r_step  <= n_step;
                r_ms    <= n_ms;
                r_tick  <= n_tick;
                r_shift <= n_shift;
                r_bit   <= n_bit;
                r_phase <= n_phase;
                r_widx  <= n_widx;
                r_pix   <= n_pix;
                r_half  <= n_half;
                r_color <= n_color;
                r_init  <= n_init;
            end
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out <= pins;
        end
    end

endmodule

/* hdl/spi_lcd_init_and_fill_controller.sv */
// a tick request is held in the request queue, then its pin levels in the output register
// throughput: one tick request per cycle while the output is not stalled, set by the sequencer update
// a two-entry request queue and one output register part the two channels
// reset: synchronous, active low; sequencer restarts the panel power-up sequence
// config registers return to 1000 ticks/ms, last column 79, last row 159
// ----------------------------------------------------------------------------
// spi_lcd_init_and_fill_controller
// Tick-driven power-up and window fill driver for a 4-wire serial TFT panel.
// ----------------------------------------------------------------------------
module spi_lcd_init_and_fill_controller
    import slcd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_start_fill,
    input  logic [15:0] i_fill_color,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_serial_clock,
    output logic        o_serial_data,
    output logic        o_chip_select_n,
    output logic        o_data_select,
    output logic        o_panel_reset_n,
    output logic        o_busy_res,
    output logic        o_ready_res
);

    logic [15:0]           r_tpm;
    logic [COORD_BITS-1:0] r_last_col;
    logic [COORD_BITS-1:0] r_last_row;
    logic                  cfg_wr;
    logic                  q_valid;
    logic                  q_pop;
    t_tick                 q_tick;
    t_pins                 pins;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpm      <= TPM_RESET;
            r_last_col <= COORD_BITS'(LAST_COL_RESET);
            r_last_row <= COORD_BITS'(LAST_ROW_RESET);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_TPM:      r_tpm      <= pwdata[15:0];
                REG_LAST_COL: r_last_col <= pwdata[COORD_BITS-1:0];
                REG_LAST_ROW: r_last_row <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TPM:      prdata = 32'(r_tpm);
            REG_LAST_COL: prdata = 32'(r_last_col);
            REG_LAST_ROW: prdata = 32'(r_last_row);
            default:      prdata = 32'd0;
        endcase
    end

    slcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_start_fill (i_start_fill),
        .i_fill_color (i_fill_color),
        .o_q_valid    (q_valid),
        .o_q_tick     (q_tick),
        .i_q_pop      (q_pop)
    );

    slcd_seq #(
        .COORD_BITS (COORD_BITS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ticks_per_ms (r_tpm),
        .i_last_column  (r_last_col),
        .i_last_row     (r_last_row),
        .i_q_valid      (q_valid),
        .i_q_tick       (q_tick),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pins         (pins)
    );

    assign o_serial_clock  = pins.serial_clock;
    assign o_serial_data   = pins.serial_data;
    assign o_chip_select_n = pins.chip_select_n;
    assign o_data_select   = pins.data_select;
    assign o_panel_reset_n = pins.panel_reset_n;
    assign o_busy_res      = pins.busy;
    assign o_ready_res     = pins.ready;

endmodule

/* hdl/slcd_checker.sv */
// ----------------------------------------------------------------------------
// slcd_checker
// Port-level checks of the panel controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slcd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_serial_clock,
    input logic o_serial_data,
    input logic o_chip_select_n,
    input logic o_data_select,
    input logic o_panel_reset_n,
    input logic o_busy_res,
    input logic o_ready_res
);

    // a stalled request keeps its clock, data, chip select and busy levels
    `SLCD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_serial_clock) && $stable(o_serial_data) && $stable(o_chip_select_n) && $stable(o_busy_res), "stalled result changed")

    // no byte on the wire: bus parks with clock high and data low
    `SLCD_ASSERT_NOW(a_bus_park, i_clk, i_rst_n, o_out_valid && o_chip_select_n, o_serial_clock && !o_serial_data && !o_data_select, "bus not parked while deselected")

    // idle only after the power-up sequence finished
    `SLCD_ASSERT_NOW(a_idle_ready, i_clk, i_rst_n, o_out_valid && !o_busy_res, o_ready_res, "idle before power-up done")

    // panel reset pulse happens before any byte and before ready
    `SLCD_ASSERT_NOW(a_rst_pulse, i_clk, i_rst_n, o_out_valid && !o_panel_reset_n, !o_ready_res && o_chip_select_n && o_busy_res, "bad state during panel reset")

endmodule

bind spi_lcd_init_and_fill_controller slcd_checker u_slcd_checker (.*);
